@@ hw/rtl/script_lexer_assert.svh @@
// assertion macros shared by the script lexer checkers
`ifndef SCRIPT_LEXER_ASSERT_SVH
`define SCRIPT_LEXER_ASSERT_SVH

// clocked check, switched off while reset is high
`define SLX_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("script lexer check failed");

// clocked check that also holds through reset
`define SLX_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("script lexer reset check failed");

`endif

@@ hw/rtl/slx_pkg.sv @@
// shared types, constants and keyword table of the script lexer
package slx_pkg;

   localparam int KEYWORD_CHARS_DEF = 7;
   localparam int LINE_BITS_DEF     = 32;
   localparam int MAX_RESULTS       = 3;
   localparam int QUEUE_DEPTH       = 8;
   localparam int KEYWORD_COUNT     = 13;
   localparam int KEYWORD_MAX       = 7;
   localparam int TYPE_BITS         = 5;

   typedef logic [7:0]           byte_type;
   typedef logic [TYPE_BITS-1:0] tok_type;

   localparam tok_type TOK_SEMI      = 5'd0;
   localparam tok_type TOK_COMMA     = 5'd1;
   localparam tok_type TOK_ASSIGN    = 5'd2;
   localparam tok_type TOK_ADD       = 5'd3;
   localparam tok_type TOK_SUB       = 5'd4;
   localparam tok_type TOK_MUL       = 5'd5;
   localparam tok_type TOK_DIV       = 5'd6;
   localparam tok_type TOK_LPAREN    = 5'd7;
   localparam tok_type TOK_RPAREN    = 5'd8;
   localparam tok_type TOK_LBRACE    = 5'd9;
   localparam tok_type TOK_RBRACE    = 5'd10;
   localparam tok_type TOK_STRING    = 5'd11;
   localparam tok_type TOK_FUNC      = 5'd12;
   localparam tok_type TOK_RETURN    = 5'd13;
   localparam tok_type TOK_PRIMITIVE = 5'd14;
   localparam tok_type TOK_IDENT     = 5'd15;
   localparam tok_type TOK_NUMBER    = 5'd16;

   // keyword spelling, zero padded
   localparam byte_type KW_TEXT [KEYWORD_COUNT][KEYWORD_MAX] = '{
      '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00},
      '{"i", "n", "t", "8", 8'h00, 8'h00, 8'h00},
      '{"u", "i", "n", "t", "8", 8'h00, 8'h00},
      '{"i", "n", "t", "1", "6", 8'h00, 8'h00},
      '{"u", "i", "n", "t", "1", "6", 8'h00},
      '{"i", "n", "t", "3", "2", 8'h00, 8'h00},
      '{"u", "i", "n", "t", "3", "2", 8'h00},
      '{"i", "n", "t", "6", "4", 8'h00, 8'h00},
      '{"u", "i", "n", "t", "6", "4", 8'h00},
      '{"f", "l", "o", "a", "t", "3", "2"},
      '{"f", "l", "o", "a", "t", "6", "4"},
      '{"s", "t", "r", "i", "n", "g", 8'h00}
   };

   localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
      4'd4, 4'd6, 4'd4, 4'd5, 4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd7, 4'd7, 4'd6
   };

   localparam tok_type KW_TYPE [KEYWORD_COUNT] = '{
      TOK_FUNC, TOK_RETURN, TOK_PRIMITIVE, TOK_PRIMITIVE, TOK_PRIMITIVE,
      TOK_PRIMITIVE, TOK_PRIMITIVE, TOK_PRIMITIVE, TOK_PRIMITIVE, TOK_PRIMITIVE,
      TOK_PRIMITIVE, TOK_PRIMITIVE, TOK_PRIMITIVE
   };

   // one response as it sits in the output queue
   typedef struct packed {
      tok_type     token_type;
      logic [31:0] token_line;
      byte_type    value_char;
      logic        char_valid;
      logic        token_end;
      logic        last_of_step;
   } rsp_type;

   // responses produced by one request, in order
   typedef struct packed {
      logic [1:0]                    count;
      rsp_type [MAX_RESULTS-1:0]     items;
   } push_type;

endpackage

@@ hw/rtl/slx_if.sv @@
// request and response channel interfaces of the script lexer

interface slx_req_if;
   logic                valid;
   logic                ready;
   slx_pkg::byte_type   char_in;
   logic                end_of_source;

   modport source (output valid, output char_in, output end_of_source, input ready);
   modport sink   (input valid, input char_in, input end_of_source, output ready);
endinterface

interface slx_rsp_if;
   logic                valid;
   logic                ready;
   slx_pkg::tok_type    token_type;
   logic [31:0]         token_line;
   slx_pkg::byte_type   value_char;
   logic                char_valid;
   logic                token_end;
   logic                last_of_step;

   modport source (output valid, output token_type, output token_line, output value_char,
                   output char_valid, output token_end, output last_of_step, input ready);
   modport sink   (input valid, input token_type, input token_line, input value_char,
                   input char_valid, input token_end, input last_of_step, output ready);
endinterface

@@ hw/rtl/script_lexer.sv @@
// top level of the script lexer: request register, scan core and response queue
//
// streaming tokenizer: source bytes come in one per request and each token goes
// out as a run of responses, one value character each, the last one flagged
// token_end and carrying the final token type (keywords are resolved there).
// strings, identifiers and numbers close with a response that holds no
// character; single-character tokens are one response with both flags set.
// a held slash is the only lookahead, comments are skipped, string escapes
// are decoded and unknown escapes dropped, whitespace and stray bytes vanish.
// token_line is the line the token started on; the line counter saturates.
// a request with end_of_source flushes the open token and returns the lexer
// to its reset state. throughput is one request per cycle: a request is held in
// the request register, the scan core resolves it combinationally from there
// and writes its zero to three responses into an eight-entry queue, which
// sends one response per cycle. a request waits in the register while the
// queue has fewer than three free entries, so bursts of multi-response
// requests or a stalling receiver slow the input down. from request to first
// response, a request passes the request register and the queue storage.
module script_lexer #(
   parameter int KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF,
   parameter int LINE_BITS     = slx_pkg::LINE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   slx_req_if.sink   req_chan,
   slx_rsp_if.source rsp_chan
);

   // request register
   logic              in_valid_ff, in_valid_in;
   slx_pkg::byte_type in_char_ff, in_char_in;
   logic              in_eos_ff, in_eos_in;

   logic              space_ok;
   logic              fire;
   slx_pkg::push_type push;

   // the held request is scanned once the queue can take its worst case
   assign fire           = in_valid_ff && space_ok;
   assign req_chan.ready = !in_valid_ff || fire;

   assign in_valid_in = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign in_char_in  = (req_chan.valid && req_chan.ready) ? req_chan.char_in : in_char_ff;
   assign in_eos_in   = (req_chan.valid && req_chan.ready) ? req_chan.end_of_source
                                                           : in_eos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_eos_ff  <= in_eos_in;
   end

   // scan core: lexer state plus the per-byte decision
   slx_core #(
      .KEYWORD_CHARS (KEYWORD_CHARS),
      .LINE_BITS     (LINE_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .char_in       (in_char_ff),
      .end_of_source (in_eos_ff),
      .push          (push)
   );

   // response queue absorbs bursts of up to three responses
   slx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ hw/rtl/slx_core.sv @@
// lexer state and the per-byte scan logic
module slx_core #(
   parameter int KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF,
   parameter int LINE_BITS     = slx_pkg::LINE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  slx_pkg::byte_type  char_in,
   input  logic               end_of_source,
   output slx_pkg::push_type  push
);

   localparam int WLW = $clog2(KEYWORD_CHARS + 2);
   localparam int IXW = $clog2(KEYWORD_CHARS);

   localparam logic [3:0] M_IDLE       = 4'd0;
   localparam logic [3:0] M_SLASH      = 4'd1;
   localparam logic [3:0] M_LINE_CMT   = 4'd2;
   localparam logic [3:0] M_BLOCK      = 4'd3;
   localparam logic [3:0] M_BLOCK_STAR = 4'd4;
   localparam logic [3:0] M_STRING     = 4'd5;
   localparam logic [3:0] M_ESCAPE     = 4'd6;
   localparam logic [3:0] M_IDENT      = 4'd7;
   localparam logic [3:0] M_NUMBER     = 4'd8;

   logic [3:0]                              mode_ff, mode_in;
   logic [LINE_BITS-1:0]                    line_ff, line_in;
   logic [LINE_BITS-1:0]                    start_ff, start_in;
   logic [KEYWORD_CHARS-1:0][7:0]           word_ff, word_in;
   logic [WLW-1:0]                          wlen_ff, wlen_in;

   logic                                    do_idle;
   logic                                    bump;
   logic                                    is_alpha;
   logic                                    is_digit;
   logic                                    sgl_hit;
   slx_pkg::tok_type                        sgl_type;
   logic [1:0]                              n;
   slx_pkg::rsp_type [slx_pkg::MAX_RESULTS-1:0] items;

   function automatic logic [31:0] line_out(input logic [LINE_BITS-1:0] v);
      logic [LINE_BITS+31:0] wide;
      wide = (LINE_BITS + 32)'(v);
      if (wide[LINE_BITS+31:32] != '0) return '1;
      return wide[31:0];
   endfunction

   function automatic slx_pkg::rsp_type make_rsp(input slx_pkg::tok_type t,
                                                  input slx_pkg::byte_type ch,
                                                  input logic v, input logic e,
                                                  input logic [LINE_BITS-1:0] ln);
      slx_pkg::rsp_type r;
      r.token_type   = t;
      r.token_line   = line_out(ln);
      r.value_char   = v ? ch : 8'h00;
      r.char_valid   = v;
      r.token_end    = e;
      r.last_of_step = 1'b0;
      return r;
   endfunction

   // names longer than the buffer never match, since no keyword is longer than it
   function automatic slx_pkg::tok_type keyword_type(input logic [KEYWORD_CHARS-1:0][7:0] w,
                                                     input logic [WLW-1:0] len);
      slx_pkg::tok_type t;
      logic             hit;
      t = slx_pkg::TOK_IDENT;
      for (int k = 0; k < slx_pkg::KEYWORD_COUNT; k++) begin
         hit = (len == WLW'(slx_pkg::KW_LEN[k]));
         for (int i = 0; i < slx_pkg::KEYWORD_MAX; i++) begin
            if (i < int'(slx_pkg::KW_LEN[k]) && w[i] != slx_pkg::KW_TEXT[k][i]) hit = 1'b0;
         end
         if (hit) t = slx_pkg::KW_TYPE[k];
      end
      return t;
   endfunction

   assign is_alpha = (char_in >= "a" && char_in <= "z") || (char_in >= "A" && char_in <= "Z");
   assign is_digit = char_in >= "0" && char_in <= "9";

   always_comb begin
      sgl_hit  = 1'b1;
      sgl_type = slx_pkg::TOK_SEMI;
      unique case (char_in)
         ";":     sgl_type = slx_pkg::TOK_SEMI;
         ",":     sgl_type = slx_pkg::TOK_COMMA;
         "=":     sgl_type = slx_pkg::TOK_ASSIGN;
         "+":     sgl_type = slx_pkg::TOK_ADD;
         "-":     sgl_type = slx_pkg::TOK_SUB;
         "*":     sgl_type = slx_pkg::TOK_MUL;
         "(":     sgl_type = slx_pkg::TOK_LPAREN;
         ")":     sgl_type = slx_pkg::TOK_RPAREN;
         "{":     sgl_type = slx_pkg::TOK_LBRACE;
         "}":     sgl_type = slx_pkg::TOK_RBRACE;
         default: sgl_hit  = 1'b0;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      start_in = start_ff;
      word_in  = word_ff;
      wlen_in  = wlen_ff;
      do_idle  = 1'b0;
      bump     = 1'b0;
      n        = 2'd0;
      items    = '0;

      // mode-specific handling
      unique case (mode_ff)
         M_SLASH: begin
            if (char_in == "/") begin
               mode_in = M_LINE_CMT;
            end else if (char_in == "*") begin
               mode_in = M_BLOCK_STAR;
            end else begin
               items[n] = make_rsp(slx_pkg::TOK_DIV, "/", 1'b1, 1'b1, start_in);
               n        = n + 2'd1;
               mode_in  = M_IDLE;
               do_idle  = 1'b1;
            end
         end
         M_LINE_CMT: begin
            if (char_in == 8'h0A) begin
               bump    = 1'b1;
               mode_in = M_IDLE;
            end
         end
         M_BLOCK: begin
            if (char_in == 8'h0A) bump = 1'b1;
            else if (char_in == "*") mode_in = M_BLOCK_STAR;
         end
         M_BLOCK_STAR: begin
            if (char_in == "/") begin
               mode_in = M_IDLE;
            end else if (char_in != "*") begin
               bump    = char_in == 8'h0A;
               mode_in = M_BLOCK;
            end
         end
         M_STRING: begin
            if (char_in == "\"") begin
               items[n] = make_rsp(slx_pkg::TOK_STRING, 8'h00, 1'b0, 1'b1, start_in);
               n        = n + 2'd1;
               mode_in  = M_IDLE;
            end else if (char_in == "\\") begin
               mode_in = M_ESCAPE;
            end else begin
               bump     = char_in == 8'h0A;
               items[n] = make_rsp(slx_pkg::TOK_STRING, char_in, 1'b1, 1'b0, start_in);
               n        = n + 2'd1;
            end
         end
         M_ESCAPE: begin
            mode_in = M_STRING;
            unique case (char_in)
               "n": begin
                  items[n] = make_rsp(slx_pkg::TOK_STRING, 8'h0A, 1'b1, 1'b0, start_in);
                  n        = n + 2'd1;
               end
               "t": begin
                  items[n] = make_rsp(slx_pkg::TOK_STRING, 8'h09, 1'b1, 1'b0, start_in);
                  n        = n + 2'd1;
               end
               "\"": begin
                  items[n] = make_rsp(slx_pkg::TOK_STRING, 8'h22, 1'b1, 1'b0, start_in);
                  n        = n + 2'd1;
               end
               "\\": begin
                  items[n] = make_rsp(slx_pkg::TOK_STRING, 8'h5C, 1'b1, 1'b0, start_in);
                  n        = n + 2'd1;
               end
               "v": begin
                  items[n] = make_rsp(slx_pkg::TOK_STRING, 8'h0B, 1'b1, 1'b0, start_in);
                  n        = n + 2'd1;
               end
               "r": begin
                  items[n] = make_rsp(slx_pkg::TOK_STRING, 8'h0D, 1'b1, 1'b0, start_in);
                  n        = n + 2'd1;
               end
               "f": begin
                  items[n] = make_rsp(slx_pkg::TOK_STRING, 8'h0C, 1'b1, 1'b0, start_in);
                  n        = n + 2'd1;
               end
               "0": begin
                  items[n] = make_rsp(slx_pkg::TOK_STRING, 8'h00, 1'b1, 1'b0, start_in);
                  n        = n + 2'd1;
               end
               // unknown escape is dropped, a newline still counts
               default: bump = char_in == 8'h0A;
            endcase
         end
         M_IDENT: begin
            if (is_alpha || is_digit) begin
               if (wlen_ff < WLW'(KEYWORD_CHARS)) word_in[wlen_ff[IXW-1:0]] = char_in;
               if (wlen_ff <= WLW'(KEYWORD_CHARS)) wlen_in = wlen_ff + WLW'(1);
               items[n] = make_rsp(slx_pkg::TOK_IDENT, char_in, 1'b1, 1'b0, start_in);
               n        = n + 2'd1;
            end else begin
               items[n] = make_rsp(keyword_type(word_ff, wlen_ff), 8'h00, 1'b0, 1'b1,
                                   start_in);
               n        = n + 2'd1;
               mode_in  = M_IDLE;
               do_idle  = 1'b1;
            end
         end
         M_NUMBER: begin
            if (is_digit || char_in == ".") begin
               items[n] = make_rsp(slx_pkg::TOK_NUMBER, char_in, 1'b1, 1'b0, start_in);
               n        = n + 2'd1;
            end else begin
               items[n] = make_rsp(slx_pkg::TOK_NUMBER, 8'h00, 1'b0, 1'b1, start_in);
               n        = n + 2'd1;
               mode_in  = M_IDLE;
               do_idle  = 1'b1;
            end
         end
         default: begin
            mode_in = M_IDLE;
            do_idle = 1'b1;
         end
      endcase

      // byte seen from idle, possibly after closing a token
      if (do_idle) begin
         priority if (char_in == 8'h0A) begin
            bump = 1'b1;
         end else if (char_in == "/") begin
            start_in = line_ff;
            mode_in  = M_SLASH;
         end else if (sgl_hit) begin
            start_in = line_ff;
            items[n] = make_rsp(sgl_type, char_in, 1'b1, 1'b1, start_in);
            n        = n + 2'd1;
         end else if (char_in == "\"") begin
            start_in = line_ff;
            mode_in  = M_STRING;
         end else if (is_alpha) begin
            start_in   = line_ff;
            word_in[0] = char_in;
            wlen_in    = WLW'(1);
            items[n]   = make_rsp(slx_pkg::TOK_IDENT, char_in, 1'b1, 1'b0, start_in);
            n          = n + 2'd1;
            mode_in    = M_IDENT;
         end else if (is_digit) begin
            start_in = line_ff;
            items[n] = make_rsp(slx_pkg::TOK_NUMBER, char_in, 1'b1, 1'b0, start_in);
            n        = n + 2'd1;
            mode_in  = M_NUMBER;
         end else begin
            mode_in = mode_in;
         end
      end

      // saturating line count
      if (bump && line_ff != '1) line_in = line_ff + LINE_BITS'(1);

      // end of source: flush open token, drop open comment, back to reset state
      if (end_of_source) begin
         unique case (mode_in)
            M_SLASH: begin
               items[n] = make_rsp(slx_pkg::TOK_DIV, "/", 1'b1, 1'b1, start_in);
               n        = n + 2'd1;
            end
            M_STRING, M_ESCAPE: begin
               items[n] = make_rsp(slx_pkg::TOK_STRING, 8'h00, 1'b0, 1'b1, start_in);
               n        = n + 2'd1;
            end
            M_IDENT: begin
               items[n] = make_rsp(keyword_type(word_in, wlen_in), 8'h00, 1'b0, 1'b1,
                                   start_in);
               n        = n + 2'd1;
            end
            M_NUMBER: begin
               items[n] = make_rsp(slx_pkg::TOK_NUMBER, 8'h00, 1'b0, 1'b1, start_in);
               n        = n + 2'd1;
            end
            default: begin
               n = n;
            end
         endcase
         mode_in  = M_IDLE;
         line_in  = LINE_BITS'(1);
         start_in = LINE_BITS'(1);
         wlen_in  = '0;
      end

      if (n != 2'd0) items[n - 2'd1].last_of_step = 1'b1;
   end

   assign push.count = fire ? n : 2'd0;
   assign push.items = items;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         line_ff  <= LINE_BITS'(1);
         start_ff <= LINE_BITS'(1);
         wlen_ff  <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         start_ff <= start_in;
         wlen_ff  <= wlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) word_ff <= word_in;
   end

endmodule

@@ hw/rtl/slx_queue.sv @@
// response queue, takes up to three responses a cycle and sends one while the receiver is ready
module slx_queue (
   input  logic              clock,
   input  logic              reset,
   input  slx_pkg::push_type push,
   output logic              space_ok,
   slx_rsp_if.source         rsp_chan
);

   localparam int DEPTH = slx_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   slx_pkg::rsp_type mem_ff [DEPTH];
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             pop;
   slx_pkg::rsp_type head;

   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign space_ok = count_ff <= CW'(DEPTH - slx_pkg::MAX_RESULTS);

   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int m = 0; m < slx_pkg::MAX_RESULTS; m++) begin
         if (m < int'(push.count)) mem_ff[wr_ptr_ff + PW'(m)] <= push.items[m];
      end
   end

   assign head = mem_ff[rd_ptr_ff];

   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.token_type   = head.token_type;
   assign rsp_chan.token_line   = head.token_line;
   assign rsp_chan.value_char   = head.value_char;
   assign rsp_chan.char_valid   = head.char_valid;
   assign rsp_chan.token_end    = head.token_end;
   assign rsp_chan.last_of_step = head.last_of_step;

endmodule

@@ hw/rtl/slx_checker.sv @@
// port-level checks on the script lexer response channel, bound to the top level
`include "script_lexer_assert.svh"

module slx_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input slx_pkg::tok_type  rsp_token_type,
   input logic [31:0]       rsp_token_line,
   input slx_pkg::byte_type rsp_value_char,
   input logic              rsp_char_valid,
   input logic              rsp_token_end,
   input logic              rsp_last_of_step
);

   // a stalled response holds
   `SLX_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_type) && $stable(rsp_token_line) && $stable(rsp_value_char) && $stable(rsp_last_of_step))

   // a response without a character always closes its token
   `SLX_ASSERT(a_empty_closes, rsp_valid && !rsp_char_valid |-> rsp_token_end && rsp_value_char == 8'h00)

   // lines count from one
   `SLX_ASSERT(a_line_nonzero, rsp_valid |-> rsp_token_line != 32'd0)

   // reset empties the queue
   `SLX_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

endmodule

bind script_lexer slx_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_token_type   (rsp_chan.token_type),
   .rsp_token_line   (rsp_chan.token_line),
   .rsp_value_char   (rsp_chan.value_char),
   .rsp_char_valid   (rsp_chan.char_valid),
   .rsp_token_end    (rsp_chan.token_end),
   .rsp_last_of_step (rsp_chan.last_of_step)
);

@@ test/testbench.sv @@
// self-checking testbench for the script lexer: directed and random source text
`timescale 1ns / 100ps

module testbench;

   // character codes that have no printable spelling
   localparam slx_pkg::byte_type CH_NUL = 8'h00;
   localparam slx_pkg::byte_type CH_TAB = 8'h09;
   localparam slx_pkg::byte_type CH_NL  = 8'h0A;
   localparam slx_pkg::byte_type CH_VT  = 8'h0B;
   localparam slx_pkg::byte_type CH_FF  = 8'h0C;
   localparam slx_pkg::byte_type CH_CR  = 8'h0D;

   // scanner states of the predictor
   localparam logic [3:0] LX_IDLE       = 4'd0;
   localparam logic [3:0] LX_SLASH      = 4'd1;
   localparam logic [3:0] LX_LINE_CMT   = 4'd2;
   localparam logic [3:0] LX_BLOCK      = 4'd3;
   localparam logic [3:0] LX_BLOCK_STAR = 4'd4;
   localparam logic [3:0] LX_STRING     = 4'd5;
   localparam logic [3:0] LX_ESCAPE     = 4'd6;
   localparam logic [3:0] LX_IDENT      = 4'd7;
   localparam logic [3:0] LX_NUMBER     = 4'd8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;

   slx_req_if req_chan ();
   slx_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   script_lexer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idling mix of the current phase, in percent
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   int error_count = 0;
   int bytes_sent = 0;
   int responses_checked = 0;
   int tokens_closed = 0;

   // predictor state: mirrors what the lexer holds between requests
   logic [3:0]        lex_state;
   logic [31:0]       line_no;
   logic [31:0]       token_start_line;
   slx_pkg::byte_type word_chars [7];
   int                word_len;

   slx_pkg::rsp_type  step_tokens [$];     // responses caused by the request being predicted
   slx_pkg::rsp_type  expected_tokens [$]; // responses still owed by the lexer, oldest first
   slx_pkg::byte_type frag_bytes [$];      // random source fragment being built

   string kw_spellings [13] = '{
      "func", "return", "int8", "uint8", "int16", "uint16", "int32",
      "uint32", "int64", "uint64", "float32", "float64", "string"
   };

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // token predictor
   // ---------------------------------------------------------------------

   function automatic void lexer_clear();
      lex_state = LX_IDLE;
      line_no = 32'd1;
      token_start_line = 32'd1;
      word_len = 0;
      foreach (word_chars[i]) word_chars[i] = CH_NUL;
   endfunction

   function automatic void emit_token(input slx_pkg::tok_type kind,
                                      input slx_pkg::byte_type ch,
                                      input logic has_char, input logic closes);
      slx_pkg::rsp_type r;
      r.token_type   = kind;
      r.token_line   = token_start_line;
      r.value_char   = has_char ? ch : CH_NUL;
      r.char_valid   = has_char;
      r.token_end    = closes;
      r.last_of_step = 1'b0;
      step_tokens.push_back(r);
   endfunction

   // line counter sticks at all ones
   function automatic void count_line();
      if (line_no != '1) line_no++;
   endfunction

   function automatic bit is_alpha(input slx_pkg::byte_type c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_digit(input slx_pkg::byte_type c);
      return c >= "0" && c <= "9";
   endfunction

   // only the first seven characters are stored, the length runs one past
   function automatic void add_word_char(input slx_pkg::byte_type c);
      if (word_len < 7) word_chars[word_len] = c;
      if (word_len <= 7) word_len++;
   endfunction

   // keyword lookup on the buffered name, longer names stay identifiers
   function automatic slx_pkg::tok_type word_kind();
      logic [55:0] w;
      w = '0;
      if (word_len > 7) return slx_pkg::TOK_IDENT;
      for (int i = 0; i < word_len; i++) w = {w[47:0], word_chars[i]};
      case (w)
         "func":   return slx_pkg::TOK_FUNC;
         "return": return slx_pkg::TOK_RETURN;
         "int8", "uint8", "int16", "uint16", "int32", "uint32", "int64", "uint64",
         "float32", "float64", "string":
            return slx_pkg::TOK_PRIMITIVE;
         default:  return slx_pkg::TOK_IDENT;
      endcase
   endfunction

   function automatic void start_token(input slx_pkg::byte_type c);
      slx_pkg::tok_type kind;
      bit               single;
      single = 1'b1;
      case (c)
         ";": kind = slx_pkg::TOK_SEMI;
         ",": kind = slx_pkg::TOK_COMMA;
         "=": kind = slx_pkg::TOK_ASSIGN;
         "+": kind = slx_pkg::TOK_ADD;
         "-": kind = slx_pkg::TOK_SUB;
         "*": kind = slx_pkg::TOK_MUL;
         "(": kind = slx_pkg::TOK_LPAREN;
         ")": kind = slx_pkg::TOK_RPAREN;
         "{": kind = slx_pkg::TOK_LBRACE;
         "}": kind = slx_pkg::TOK_RBRACE;
         default: begin
            kind = slx_pkg::TOK_SEMI;
            single = 1'b0;
         end
      endcase
      if (c == CH_NL) begin
         count_line();
      end else if (c == "/") begin
         token_start_line = line_no;
         lex_state = LX_SLASH;
      end else if (single) begin
         token_start_line = line_no;
         emit_token(kind, c, 1'b1, 1'b1);
      end else if (c == "\"") begin
         token_start_line = line_no;
         lex_state = LX_STRING;
      end else if (is_alpha(c)) begin
         token_start_line = line_no;
         word_len = 0;
         add_word_char(c);
         emit_token(slx_pkg::TOK_IDENT, c, 1'b1, 1'b0);
         lex_state = LX_IDENT;
      end else if (is_digit(c)) begin
         token_start_line = line_no;
         emit_token(slx_pkg::TOK_NUMBER, c, 1'b1, 1'b0);
         lex_state = LX_NUMBER;
      end
   endfunction

   function automatic void scan_byte(input slx_pkg::byte_type c);
      slx_pkg::byte_type decoded;
      bit                known;
      case (lex_state)
         LX_SLASH: begin
            if (c == "/") lex_state = LX_LINE_CMT;
            else if (c == "*") lex_state = LX_BLOCK_STAR;
            else begin
               // a lone slash is a divide, the byte after it starts fresh
               emit_token(slx_pkg::TOK_DIV, "/", 1'b1, 1'b1);
               lex_state = LX_IDLE;
               start_token(c);
            end
         end
         LX_LINE_CMT: begin
            if (c == CH_NL) begin
               count_line();
               lex_state = LX_IDLE;
            end
         end
         LX_BLOCK: begin
            if (c == CH_NL) count_line();
            else if (c == "*") lex_state = LX_BLOCK_STAR;
         end
         LX_BLOCK_STAR: begin
            // the opener's star counts, so a slash right after the opener closes
            if (c == "/") lex_state = LX_IDLE;
            else if (c != "*") begin
               if (c == CH_NL) count_line();
               lex_state = LX_BLOCK;
            end
         end
         LX_STRING: begin
            if (c == "\"") begin
               emit_token(slx_pkg::TOK_STRING, CH_NUL, 1'b0, 1'b1);
               lex_state = LX_IDLE;
            end else if (c == "\\") begin
               lex_state = LX_ESCAPE;
            end else begin
               if (c == CH_NL) count_line();
               emit_token(slx_pkg::TOK_STRING, c, 1'b1, 1'b0);
            end
         end
         LX_ESCAPE: begin
            known = 1'b1;
            decoded = CH_NUL;
            case (c)
               "n":  decoded = CH_NL;
               "t":  decoded = CH_TAB;
               "\"": decoded = "\"";
               "\\": decoded = "\\";
               "v":  decoded = CH_VT;
               "r":  decoded = CH_CR;
               "f":  decoded = CH_FF;
               "0":  decoded = CH_NUL;
               default: begin
                  // unknown escape vanishes, an escaped newline still counts
                  known = 1'b0;
                  if (c == CH_NL) count_line();
               end
            endcase
            if (known) emit_token(slx_pkg::TOK_STRING, decoded, 1'b1, 1'b0);
            lex_state = LX_STRING;
         end
         LX_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
               add_word_char(c);
               emit_token(slx_pkg::TOK_IDENT, c, 1'b1, 1'b0);
            end else begin
               emit_token(word_kind(), CH_NUL, 1'b0, 1'b1);
               lex_state = LX_IDLE;
               start_token(c);
            end
         end
         LX_NUMBER: begin
            if (is_digit(c) || c == ".") begin
               emit_token(slx_pkg::TOK_NUMBER, c, 1'b1, 1'b0);
            end else begin
               emit_token(slx_pkg::TOK_NUMBER, CH_NUL, 1'b0, 1'b1);
               lex_state = LX_IDLE;
               start_token(c);
            end
         end
         default: begin
            lex_state = LX_IDLE;
            start_token(c);
         end
      endcase
   endfunction

   // expected responses of one accepted request go to the back of the queue
   function automatic void predict_request(input slx_pkg::byte_type c, input logic eos);
      step_tokens.delete();
      scan_byte(c);
      if (eos) begin
         // flush whatever is open, comments are simply dropped
         case (lex_state)
            LX_SLASH:             emit_token(slx_pkg::TOK_DIV, "/", 1'b1, 1'b1);
            LX_STRING, LX_ESCAPE: emit_token(slx_pkg::TOK_STRING, CH_NUL, 1'b0, 1'b1);
            LX_IDENT:             emit_token(word_kind(), CH_NUL, 1'b0, 1'b1);
            LX_NUMBER:            emit_token(slx_pkg::TOK_NUMBER, CH_NUL, 1'b0, 1'b1);
            default: ;
         endcase
         lexer_clear();
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_step = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------

   // one source byte; idle cycles first, then hold valid until ready
   task automatic send_byte(input slx_pkg::byte_type c, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.char_in <= c;
      req_chan.end_of_source <= eos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_request(c, eos);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input logic eos_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], eos_last && (i == s.len() - 1));
   endtask

   // ---------------------------------------------------------------------
   // response checker: random stalls, each response against the oldest expectation
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      slx_pkg::rsp_type got;
      slx_pkg::rsp_type want;
      if (reset) begin
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.token_type   = rsp_chan.token_type;
            got.token_line   = rsp_chan.token_line;
            got.value_char   = rsp_chan.value_char;
            got.char_valid   = rsp_chan.char_valid;
            got.token_end    = rsp_chan.token_end;
            got.last_of_step = rsp_chan.last_of_step;
            if (expected_tokens.size() == 0) begin
               report_mismatch($sformatf("unexpected response type %0d char %h",
                                         got.token_type, got.value_char));
            end else begin
               want = expected_tokens.pop_front();
               responses_checked++;
               if (want.token_end) tokens_closed++;
               if (got.token_type !== want.token_type)
                  report_mismatch($sformatf("token_type %0d, want %0d",
                                            got.token_type, want.token_type));
               if (got.token_line !== want.token_line)
                  report_mismatch($sformatf("token_line %0d, want %0d",
                                            got.token_line, want.token_line));
               if (got.value_char !== want.value_char)
                  report_mismatch($sformatf("value_char %h, want %h",
                                            got.value_char, want.value_char));
               if (got.char_valid !== want.char_valid)
                  report_mismatch($sformatf("char_valid %b, want %b",
                                            got.char_valid, want.char_valid));
               if (got.token_end !== want.token_end)
                  report_mismatch($sformatf("token_end %b, want %b",
                                            got.token_end, want.token_end));
               if (got.last_of_step !== want.last_of_step)
                  report_mismatch($sformatf("last_of_step %b, want %b",
                                            got.last_of_step, want.last_of_step));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------

   // every single-character token
   task automatic test_punctuation();
      send_text("{(;,=+-*)}", 1'b0);
   endtask

   // divide vs comments, the slash-star-slash closer, newlines inside comments
   task automatic test_slash_cases();
      send_text("a/b//c\n/*/ /**/ /*\n**/ 7/(", 1'b0);
      send_text("/", 1'b1);   // held slash flushed as divide at end of source
   endtask

   // all escapes, an unknown one, an escaped newline, a raw newline, extreme bytes
   task automatic test_strings();
      send_text("\"a\\n\\t\\\"\\\\\\v\\r\\f\\0\\q\\\nz\nb\"", 1'b0);
      send_text("\"", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_text("\"", 1'b0);
   endtask

   // keywords, a name one past the buffer, numbers with dots
   task automatic test_words_numbers();
      send_text("func return int8 float32 float32x uint64a x1;3.14.15+7y ", 1'b0);
   endtask

   // flushing at end of source in every open state but a held slash, then the line count restarts
   task automatic test_end_of_source();
      send_text("\"ab", 1'b1);
      send_text("\"q\\", 1'b1);
      send_text("ab1", 1'b1);
      send_text("42", 1'b1);
      send_text("/*open", 1'b1);
      send_text("// tail", 1'b1);
      send_text("\n\n;", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text(";", 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // random source text
   // ---------------------------------------------------------------------

   function automatic slx_pkg::byte_type rand_alpha();
      return slx_pkg::byte_type'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
   endfunction

   function automatic slx_pkg::byte_type rand_digit();
      return slx_pkg::byte_type'("0" + $urandom_range(0, 9));
   endfunction

   function automatic slx_pkg::byte_type rand_alnum();
      return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_alpha();
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) frag_bytes.push_back(s[i]);
   endfunction

   function automatic void add_pick(input string s);
      frag_bytes.push_back(s[$urandom_range(0, s.len() - 1)]);
   endfunction

   // builds one mostly well-formed piece of script, with some noise mixed in
   task automatic send_fragment();
      frag_bytes.delete();
      case ($urandom_range(0, 13))
         0, 1: begin
            add_text(kw_spellings[$urandom_range(0, 12)]);
            // sometimes the name runs on and stops being a keyword
            if ($urandom_range(0, 3) == 0) frag_bytes.push_back(rand_alnum());
            frag_bytes.push_back(" ");
         end
         2, 3: begin
            frag_bytes.push_back(rand_alpha());
            repeat ($urandom_range(0, 9)) frag_bytes.push_back(rand_alnum());
            if ($urandom_range(0, 1)) frag_bytes.push_back(" ");
         end
         4: begin
            frag_bytes.push_back(rand_digit());
            repeat ($urandom_range(0, 5))
               frag_bytes.push_back(($urandom_range(0, 4) == 0) ? slx_pkg::byte_type'(".")
                                                                : rand_digit());
         end
         5: begin
            frag_bytes.push_back("\"");
            repeat ($urandom_range(0, 8)) begin
               case ($urandom_range(0, 5))
                  0, 1: frag_bytes.push_back(slx_pkg::byte_type'($urandom_range(32, 126)));
                  2: begin
                     frag_bytes.push_back("\\");
                     add_pick("nt\"\\vrf0");
                  end
                  3: begin
                     frag_bytes.push_back("\\");
                     frag_bytes.push_back(slx_pkg::byte_type'($urandom_range(0, 255)));
                  end
                  4: frag_bytes.push_back(CH_NL);
                  default: frag_bytes.push_back(slx_pkg::byte_type'($urandom_range(0, 255)));
               endcase
            end
            if ($urandom_range(0, 9) != 0) frag_bytes.push_back("\"");
         end
         6, 7: add_pick("{}();,=+-*");
         8: begin
            case ($urandom_range(0, 3))
               0: frag_bytes.push_back(" ");
               1: frag_bytes.push_back(CH_TAB);
               2: frag_bytes.push_back(CH_NL);
               default: frag_bytes.push_back(CH_CR);
            endcase
         end
         9: begin
            add_text("//");
            repeat ($urandom_range(0, 6))
               frag_bytes.push_back(slx_pkg::byte_type'($urandom_range(32, 126)));
            frag_bytes.push_back(CH_NL);
         end
         10: begin
            if ($urandom_range(0, 3) == 0) begin
               add_text("/*/");
            end else begin
               add_text("/*");
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 2) == 0) frag_bytes.push_back(CH_NL);
                  else add_pick("**/ab");
               end
               add_text("*/");
            end
         end
         11: begin
            frag_bytes.push_back("/");
            frag_bytes.push_back($urandom_range(0, 1) ? slx_pkg::byte_type'(" ")
                                                      : rand_digit());
         end
         default: frag_bytes.push_back(slx_pkg::byte_type'($urandom_range(0, 255)));
      endcase
      // end of source now and then, possibly in the middle of a token
      foreach (frag_bytes[i]) send_byte(frag_bytes[i], $urandom_range(0, 59) == 0);
   endtask

   // four idling mixes, about 80 bytes each
   task automatic test_random_text();
      int idle_mix [4] = '{0, 57, 0, 9};
      int stall_mix [4] = '{0, 0, 57, 9};
      int phase_start;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_mix[p];
         recv_stall_pct = stall_mix[p];
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 80) send_fragment();
      end
      send_byte(CH_NL, 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      int wait_cycles;
      req_chan.valid = 1'b0;
      req_chan.char_in = CH_NUL;
      req_chan.end_of_source = 1'b0;
      lexer_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_punctuation();
      test_slash_cases();
      test_strings();
      test_words_numbers();
      test_end_of_source();
      test_random_text();

      req_chan.valid <= 1'b0;
      send_idle_pct = 0;

      // drain: let the queue empty, then keep watching for anything stray
      wait_cycles = 0;
      while (expected_tokens.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (expected_tokens.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_tokens.size()));

      $display("summary: %0d source bytes, %0d responses checked, %0d tokens closed",
               bytes_sent, responses_checked, tokens_closed);
      $display({"summary: punctuation, comments, escapes, keywords, numbers and flushes, ",
                "under four idling mixes"});
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ script_lexer.f @@
+incdir+hw/rtl
hw/rtl/slx_pkg.sv
hw/rtl/slx_if.sv
hw/rtl/slx_core.sv
hw/rtl/slx_queue.sv
hw/rtl/script_lexer.sv
hw/rtl/slx_checker.sv
test/testbench.sv
